>>> rtl/core/flc_pkg.sv
// shared constants, types and offset helper for the floppy controller register file
package flc_pkg;

    localparam int SECTOR_BYTES      = 256;
    localparam int SECTORS_PER_TRACK = 72;
    localparam int DRIVES            = 4;

    localparam int BUF_AW  = $clog2(SECTOR_BYTES);
    localparam int CNT_W   = BUF_AW + 1;
    localparam int OFF_W   = 23;
    localparam int SIDX_W  = OFF_W - BUF_AW;
    localparam int DRV_W   = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 40;
    localparam int CFG_W   = 4;

    // actions
    localparam logic [1:0] ACT_BUS_RD   = 2'd0;
    localparam logic [1:0] ACT_BUS_WR   = 2'd1;
    localparam logic [1:0] ACT_BUF_LOAD = 2'd2;
    localparam logic [1:0] ACT_BUF_GET  = 2'd3;

    // register selects
    localparam logic [2:0] REG_DRVSEL = 3'd0;
    localparam logic [2:0] REG_CMD    = 3'd1;
    localparam logic [2:0] REG_TRACK  = 3'd2;
    localparam logic [2:0] REG_SECTOR = 3'd3;
    localparam logic [2:0] REG_DATA   = 3'd4;

    // config register indexes
    localparam logic CFG_ATTACHED = 1'b0;
    localparam logic CFG_WR_EN    = 1'b1;

    // commands
    localparam logic [7:0] CMD_READ_A  = 8'h8C;
    localparam logic [7:0] CMD_READ_B  = 8'h9C;
    localparam logic [7:0] CMD_WRITE   = 8'hAC;
    localparam logic [7:0] CMD_SEEK_A  = 8'h18;
    localparam logic [7:0] CMD_SEEK_B  = 8'h1B;
    localparam logic [7:0] CMD_RESTORE = 8'h0B;

    // status bits
    localparam logic [7:0] ST_BUSY   = 8'h01;
    localparam logic [7:0] ST_DRQ    = 8'h02;
    localparam logic [7:0] ST_WRPROT = 8'h40;
    localparam logic [7:0] ST_NOTRDY = 8'h80;

    // storage requests
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_STORE = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_buf_access;

    typedef struct packed {
        logic [7:0]       rd;
        logic             use_buf;
        logic [1:0]       req;
        logic [DRV_W-1:0] drive;
        logic [OFF_W-1:0] off;
    } t_result;

    function automatic logic [OFF_W-1:0] sector_offset(input logic [7:0] trk,
                                                       input logic [7:0] sec);
        logic [7:0]        s;
        logic [SIDX_W-1:0] n;
        s = (sec == 8'd0) ? 8'd1 : sec;
        n = SIDX_W'(int'(trk) * SECTORS_PER_TRACK + int'(s) - 1);
        return {n, BUF_AW'(0)};
    endfunction

endpackage

>>> rtl/core/flc_sector_ram.sv
// generic single-port ram with registered read data
module flc_sector_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/flc_reg_ctrl.sv
// per-drive register state, command decode and sector buffer access generation
module flc_reg_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [1:0]                       i_action,
    input  logic [2:0]                       i_reg_select,
    input  logic [7:0]                       i_write_data,
    input  logic [flc_pkg::BUF_AW-1:0]       i_buffer_index,
    input  logic [flc_pkg::CFG_W-1:0]        i_attached_mask,
    input  logic [flc_pkg::CFG_W-1:0]        i_write_enable_mask,
    output flc_pkg::t_buf_access             o_buf,
    output flc_pkg::t_result                 o_res
);
    import flc_pkg::*;

    logic [DRV_W-1:0] r_sel_drive, n_sel_drive;
    logic [7:0]       r_track  [DRIVES];
    logic [7:0]       n_track  [DRIVES];
    logic [7:0]       r_sector [DRIVES];
    logic [7:0]       n_sector [DRIVES];
    logic [CNT_W-1:0] r_count  [DRIVES];
    logic [CNT_W-1:0] n_count  [DRIVES];
    logic [7:0]       r_status [DRIVES];
    logic [7:0]       n_status [DRIVES];
    logic [7:0]       r_last_data, n_last_data;
    logic             r_wr_pending, n_wr_pending;
    logic [OFF_W-1:0] r_pend_off, n_pend_off;
    logic [DRV_W-1:0] r_pend_drive, n_pend_drive;
    logic [7:0]       r_prev_status, n_prev_status;

    logic [DRV_W-1:0] d;
    logic             attached;
    logic [CNT_W-1:0] cnt;
    logic [OFF_W-1:0] cur_off;
    logic [7:0]       stat_v;
    t_buf_access      buf_acc;
    t_result          res;

    assign d        = r_sel_drive;
    assign attached = ({1'b0, d} < 3'(DRIVES)) && i_attached_mask[d];
    assign cnt      = r_count[d];
    assign cur_off  = sector_offset(r_track[d], r_sector[d]);

    always_comb begin
        n_sel_drive   = r_sel_drive;
        n_track       = r_track;
        n_sector      = r_sector;
        n_count       = r_count;
        n_status      = r_status;
        n_last_data   = r_last_data;
        n_wr_pending  = r_wr_pending;
        n_pend_off    = r_pend_off;
        n_pend_drive  = r_pend_drive;
        n_prev_status = r_prev_status;
        buf_acc       = '0;
        res           = '0;
        stat_v        = r_status[d] & ~ST_NOTRDY;

        if (i_accept) begin
            if (i_action == ACT_BUF_LOAD) begin
                if ({1'b0, i_buffer_index} < CNT_W'(SECTOR_BYTES)) begin
                    buf_acc.we    = 1'b1;
                    buf_acc.addr  = i_buffer_index;
                    buf_acc.wdata = i_write_data;
                end
            end else if (i_action == ACT_BUF_GET) begin
                if ({1'b0, i_buffer_index} < CNT_W'(SECTOR_BYTES)) begin
                    buf_acc.re  = 1'b1;
                    buf_acc.addr = i_buffer_index;
                    res.use_buf = 1'b1;
                end
            end else begin
                case (i_reg_select)
                    REG_DRVSEL: begin
                        if (i_action == ACT_BUS_WR) begin
                            n_sel_drive = i_write_data[DRV_W-1:0];
                            if (!i_write_enable_mask[i_write_data[DRV_W-1:0]]) begin
                                n_status[i_write_data[DRV_W-1:0]] =
                                    r_status[i_write_data[DRV_W-1:0]] | ST_WRPROT;
                            end
                        end
                    end
                    REG_CMD: begin
                        if (!attached) begin
                            n_status[d] = r_status[d] | ST_NOTRDY;
                        end else begin
                            n_status[d] = stat_v;
                            if (i_action == ACT_BUS_WR) begin
                                case (i_write_data)
                                    CMD_READ_A, CMD_READ_B: begin
                                        res.req     = REQ_LOAD;
                                        res.drive   = d;
                                        res.off     = cur_off;
                                        n_status[d] = stat_v | ST_BUSY | ST_DRQ;
                                        n_count[d]  = '0;
                                    end
                                    CMD_WRITE: begin
                                        if ((r_status[d] & ST_WRPROT) == 8'h00) begin
                                            n_pend_off   = cur_off;
                                            n_pend_drive = d;
                                            n_wr_pending = 1'b1;
                                            n_status[d]  = stat_v | ST_BUSY | ST_DRQ;
                                            n_count[d]   = '0;
                                        end
                                    end
                                    CMD_SEEK_A, CMD_SEEK_B: begin
                                        n_track[d]  = r_last_data;
                                        n_status[d] = stat_v & ~(ST_BUSY | ST_DRQ);
                                    end
                                    CMD_RESTORE: begin
                                        n_track[d]  = 8'h00;
                                        n_status[d] = stat_v & ~(ST_BUSY | ST_DRQ);
                                    end
                                    default: ;
                                endcase
                            end else begin
                                // drq shows one read ahead of busy
                                if (r_prev_status == 8'h00 && stat_v == (ST_BUSY | ST_DRQ)) begin
                                    res.rd = ST_DRQ;
                                end else begin
                                    res.rd = stat_v;
                                end
                                n_prev_status = res.rd;
                            end
                        end
                    end
                    REG_TRACK: begin
                        if (i_action == ACT_BUS_WR) begin
                            n_track[d] = i_write_data;
                        end else begin
                            res.rd = r_track[d];
                        end
                    end
                    REG_SECTOR: begin
                        if (i_action == ACT_BUS_WR) begin
                            n_sector[d] = (i_write_data == 8'h00) ? 8'h01 : i_write_data;
                        end else begin
                            res.rd = (r_sector[d] == 8'h00) ? 8'h01 : r_sector[d];
                        end
                    end
                    REG_DATA: begin
                        if (i_action == ACT_BUS_WR) begin
                            n_last_data = i_write_data;
                        end
                        if (cnt < CNT_W'(SECTOR_BYTES)) begin
                            buf_acc.addr = cnt[BUF_AW-1:0];
                            if (i_action == ACT_BUS_WR) begin
                                buf_acc.we    = 1'b1;
                                buf_acc.wdata = i_write_data;
                            end else begin
                                buf_acc.re  = 1'b1;
                                res.use_buf = 1'b1;
                            end
                            n_count[d] = cnt + 1'b1;
                            if (cnt == CNT_W'(SECTOR_BYTES - 1)) begin
                                n_status[d] = r_status[d] & ~(ST_BUSY | ST_DRQ);
                                if (i_action == ACT_BUS_WR && r_wr_pending) begin
                                    res.req      = REQ_STORE;
                                    res.drive    = r_pend_drive;
                                    res.off      = r_pend_off;
                                    n_wr_pending = 1'b0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_drive   <= '0;
            r_last_data   <= 8'h00;
            r_wr_pending  <= 1'b0;
            r_pend_off    <= '0;
            r_pend_drive  <= '0;
            r_prev_status <= ST_NOTRDY;
            for (int k = 0; k < DRIVES; k++) begin
                r_track[k]  <= 8'h00;
                r_sector[k] <= 8'h00;
                r_count[k]  <= '0;
                r_status[k] <= ST_NOTRDY;
            end
        end else begin
            r_sel_drive   <= n_sel_drive;
            r_last_data   <= n_last_data;
            r_wr_pending  <= n_wr_pending;
            r_pend_off    <= n_pend_off;
            r_pend_drive  <= n_pend_drive;
            r_prev_status <= n_prev_status;
            r_track       <= n_track;
            r_sector      <= n_sector;
            r_count       <= n_count;
            r_status      <= n_status;
        end
    end

    assign o_buf = buf_acc;
    assign o_res = res;

    a_buf_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_buf.we && o_buf.re))
        else $error("buffer read and write in the same beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[d] <= CNT_W'(SECTOR_BYTES))
        else $error("byte count beyond sector size");

    a_store_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.req == REQ_STORE) |=> !r_wr_pending)
        else $error("pending store not cleared after issue");

    a_req_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.req != REQ_NONE) |-> i_accept)
        else $error("storage request without an input beat");

endmodule

>>> rtl/core/floppy_controller_registers.sv
// top level of the floppy controller register file: config registers and output stage
//
// One access is taken every clock cycle unless stalled, and its result beat appears in the
// output register in the cycle after it is accepted. Buffer bytes come from the registered read port
// of the sector buffer ram; all register-file updates complete in the accept cycle. The
// block stalls only while the output register holds a beat that the sink has not taken:
// input ready is high whenever the output register is empty or is being drained.
module floppy_controller_registers (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // action[1:0], reg_select[4:2], write_data[12:5], buffer_index[20:13]
    input  logic [flc_pkg::IN_W-1:0]      i_s_tdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // read_data[7:0], storage_request[9:8], storage_drive[11:10], storage_offset[34:12]
    output logic [flc_pkg::OUT_W-1:0]     o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [flc_pkg::CFG_W-1:0]     i_cfg_data
);
    import flc_pkg::*;

    logic [CFG_W-1:0] r_attached_mask;
    logic [CFG_W-1:0] r_wr_en_mask;
    logic             r_out_valid;
    t_result          r_res;

    logic             accept;
    logic             advance;
    t_buf_access      buf_acc;
    t_result          res;
    logic [7:0]       ram_q;
    logic [7:0]       out_rd;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attached_mask <= '0;
            r_wr_en_mask    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ATTACHED: r_attached_mask <= i_cfg_data;
                CFG_WR_EN:    r_wr_en_mask    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    flc_reg_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (accept),
        .i_action            (i_s_tdata[1:0]),
        .i_reg_select        (i_s_tdata[4:2]),
        .i_write_data        (i_s_tdata[12:5]),
        .i_buffer_index      (i_s_tdata[20:13]),
        .i_attached_mask     (r_attached_mask),
        .i_write_enable_mask (r_wr_en_mask),
        .o_buf               (buf_acc),
        .o_res               (res)
    );

    flc_sector_ram #(
        .DEPTH (SECTOR_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (buf_acc.we),
        .i_re    (buf_acc.re),
        .i_addr  (buf_acc.addr),
        .i_wdata (buf_acc.wdata),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    // buffer bytes come straight from the ram read register, held while stalled
    assign out_rd     = r_res.use_buf ? ram_q : r_res.rd;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_res.off, r_res.drive, r_res.req, out_rd};

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the floppy controller register file, with its own register model
`timescale 1ns / 1ps

module tb_top;
    import flc_pkg::*;

    localparam int         IDLE_LIMIT   = 2000;
    localparam int         PRINT_LIMIT  = 40;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [7:0] CMD_UNKNOWN  = 8'hFF;

    typedef struct packed {
        logic [1:0] act;
        logic [2:0] rsel;
        logic [7:0] wdata;
        logic [7:0] idx;
    } t_access;

    typedef struct packed {
        logic [7:0]       rd;
        logic [1:0]       req;
        logic [1:0]       drive;
        logic [OFF_W-1:0] off;
    } t_reply;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // register model state
    logic [3:0]        attach_cfg;
    logic [3:0]        wren_cfg;
    logic [1:0]        cur_drive;
    logic [7:0]        drv_track  [DRIVES];
    logic [7:0]        drv_sector [DRIVES];
    logic [8:0]        drv_count  [DRIVES];
    logic [7:0]        drv_status [DRIVES];
    logic [7:0]        buf_mem    [SECTOR_BYTES];
    logic              buf_known  [SECTOR_BYTES];
    logic [7:0]        data_latch;
    logic              store_armed;
    logic [OFF_W-1:0]  store_off;
    logic [1:0]        store_drv;
    logic [7:0]        last_status;

    t_reply            pending_replies[$];
    int                error_count  = 0;
    int                items_sent   = 0;
    int                stuck_cycles = 0;
    int                ready_hold   = 0;
    bit                no_idle      = 1'b0;

    floppy_controller_registers u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [OFF_W-1:0] image_offset(input logic [7:0] trk,
                                                      input logic [7:0] sec);
        int t;
        int s;
        int o;
        t = int'(trk);
        s = (sec == 8'd0) ? 1 : int'(sec);
        o = t * SECTORS_PER_TRACK * SECTOR_BYTES + (s - 1) * SECTOR_BYTES;
        return o[OFF_W-1:0];
    endfunction

    function automatic void reset_registers();
        attach_cfg  = '0;
        wren_cfg    = '0;
        cur_drive   = '0;
        data_latch  = '0;
        store_armed = 1'b0;
        store_off   = '0;
        store_drv   = '0;
        last_status = ST_NOTRDY;
        for (int k = 0; k < DRIVES; k++) begin
            drv_track[k]  = '0;
            drv_sector[k] = '0;
            drv_count[k]  = '0;
            drv_status[k] = ST_NOTRDY;
        end
        for (int k = 0; k < SECTOR_BYTES; k++) begin
            buf_mem[k]   = '0;
            buf_known[k] = 1'b0;
        end
    endfunction

    // one access through the register file, returns the reply beat it causes
    function automatic t_reply apply_access(input t_access a);
        t_reply     r;
        logic [1:0] d;
        logic [7:0] v;
        logic       wr;
        r  = '0;
        d  = cur_drive;
        wr = (a.act == ACT_BUS_WR);
        if (a.act == ACT_BUF_LOAD) begin
            buf_mem[a.idx]   = a.wdata;
            buf_known[a.idx] = 1'b1;
        end else if (a.act == ACT_BUF_GET) begin
            r.rd = buf_mem[a.idx];
        end else begin
            case (a.rsel)
                REG_DRVSEL: begin
                    if (wr) begin
                        cur_drive = a.wdata[1:0];
                        if (!wren_cfg[cur_drive])
                            drv_status[cur_drive] |= ST_WRPROT;
                    end
                end
                REG_CMD: begin
                    if (!attach_cfg[d]) begin
                        drv_status[d] |= ST_NOTRDY;
                    end else begin
                        drv_status[d] &= ~ST_NOTRDY;
                        if (wr) begin
                            case (a.wdata)
                                CMD_READ_A, CMD_READ_B: begin
                                    r.req   = REQ_LOAD;
                                    r.drive = d;
                                    r.off   = image_offset(drv_track[d], drv_sector[d]);
                                    drv_status[d] |= ST_BUSY | ST_DRQ;
                                    drv_count[d] = '0;
                                end
                                CMD_WRITE: begin
                                    if ((drv_status[d] & ST_WRPROT) == 8'd0) begin
                                        store_off   = image_offset(drv_track[d], drv_sector[d]);
                                        store_drv   = d;
                                        store_armed = 1'b1;
                                        drv_status[d] |= ST_BUSY | ST_DRQ;
                                        drv_count[d] = '0;
                                    end
                                end
                                CMD_SEEK_A, CMD_SEEK_B: begin
                                    drv_track[d] = data_latch;
                                    drv_status[d] &= ~(ST_BUSY | ST_DRQ);
                                end
                                CMD_RESTORE: begin
                                    drv_track[d] = '0;
                                    drv_status[d] &= ~(ST_BUSY | ST_DRQ);
                                end
                                default: ;
                            endcase
                        end else begin
                            // drq shows one read ahead of busy
                            v = drv_status[d];
                            if (last_status == 8'd0 && v == (ST_BUSY | ST_DRQ))
                                v = ST_DRQ;
                            last_status = v;
                            r.rd = v;
                        end
                    end
                end
                REG_TRACK: begin
                    if (wr)
                        drv_track[d] = a.wdata;
                    else
                        r.rd = drv_track[d];
                end
                REG_SECTOR: begin
                    if (wr)
                        drv_sector[d] = (a.wdata == 8'd0) ? 8'd1 : a.wdata;
                    else
                        r.rd = (drv_sector[d] == 8'd0) ? 8'd1 : drv_sector[d];
                end
                REG_DATA: begin
                    if (wr)
                        data_latch = a.wdata;
                    if (drv_count[d] < 9'(SECTOR_BYTES)) begin
                        if (wr) begin
                            buf_mem[drv_count[d][7:0]]   = a.wdata;
                            buf_known[drv_count[d][7:0]] = 1'b1;
                        end else begin
                            r.rd = buf_mem[drv_count[d][7:0]];
                        end
                        drv_count[d] = drv_count[d] + 9'd1;
                        if (drv_count[d] == 9'(SECTOR_BYTES)) begin
                            drv_status[d] &= ~(ST_BUSY | ST_DRQ);
                            if (wr && store_armed) begin
                                r.req       = REQ_STORE;
                                r.drive     = store_drv;
                                r.off       = store_off;
                                store_armed = 1'b0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // buffer bytes never written are not to be read: turn such reads into writes
    function automatic t_access make_legal(input t_access a);
        if (a.act == ACT_BUF_GET && !buf_known[a.idx])
            a.act = ACT_BUF_LOAD;
        else if (a.act == ACT_BUS_RD && a.rsel == REG_DATA
                 && drv_count[cur_drive] < 9'(SECTOR_BYTES)
                 && !buf_known[drv_count[cur_drive][7:0]])
            a.act = ACT_BUS_WR;
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_edge_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 7))
            0: return CMD_READ_A;
            1: return CMD_READ_B;
            2: return CMD_WRITE;
            3: return CMD_SEEK_A;
            4: return CMD_SEEK_B;
            5: return CMD_RESTORE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly an attached, writable, unprotected drive so transfers get somewhere
    function automatic logic [1:0] pick_drive();
        logic [1:0] d;
        d = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < DRIVES; k++) begin
                if (attach_cfg[d] && wren_cfg[d] && (drv_status[d] & ST_WRPROT) == 8'd0)
                    break;
                d = d + 2'd1;
            end
        end
        return d;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $realtime);
    endtask

    task automatic send_access(input logic [1:0] act, input logic [2:0] rsel,
                               input logic [7:0] wdata, input logic [7:0] idx);
        t_access a;
        int      gap;
        a.act   = act;
        a.rsel  = rsel;
        a.wdata = wdata;
        a.idx   = idx;
        a       = make_legal(a);
        gap     = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {3'b000, a.idx, a.wdata, a.rsel, a.act};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        pending_replies.push_back(apply_access(a));
        items_sent++;
    endtask

    task automatic bus_write(input logic [2:0] rsel, input logic [7:0] wdata);
        send_access(ACT_BUS_WR, rsel, wdata, 8'($urandom_range(0, 255)));
    endtask

    task automatic bus_read(input logic [2:0] rsel);
        send_access(ACT_BUS_RD, rsel, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_replies_drained();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [3:0] val);
        wait_replies_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_ATTACHED)
            attach_cfg = val;
        else
            wren_cfg = val;
        cfg_we <= 1'b0;
    endtask

    task automatic select_drive();
        logic [5:0] hi;
        hi = 6'($urandom_range(0, 63));
        bus_write(REG_DRVSEL, {hi, pick_drive()});
    endtask

    task automatic place_head();
        bus_write(REG_TRACK, pick_edge_byte());
        bus_write(REG_SECTOR, pick_edge_byte());
    endtask

    task automatic full_write_sector();
        select_drive();
        place_head();
        bus_write(REG_CMD, CMD_WRITE);
        for (int n = 0; n < SECTOR_BYTES; n++) begin
            bus_write(REG_DATA, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                bus_read(REG_CMD);
        end
        bus_read(REG_CMD);
    endtask

    task automatic full_read_sector();
        select_drive();
        place_head();
        bus_write(REG_CMD, $urandom_range(0, 1) ? CMD_READ_A : CMD_READ_B);
        // storage fills part of the buffer before the cpu drains it
        repeat ($urandom_range(0, 12))
            send_access(ACT_BUF_LOAD, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
        for (int n = 0; n < SECTOR_BYTES; n++) begin
            bus_read(REG_DATA);
            if ($urandom_range(0, 19) == 0)
                bus_read(REG_CMD);
        end
        bus_read(REG_CMD);
    endtask

    task automatic partial_transfer();
        if ($urandom_range(0, 1))
            select_drive();
        case ($urandom_range(0, 2))
            0: bus_write(REG_CMD, CMD_READ_A);
            1: bus_write(REG_CMD, CMD_READ_B);
            default: bus_write(REG_CMD, CMD_WRITE);
        endcase
        repeat ($urandom_range(1, 40)) begin
            if ($urandom_range(0, 1))
                bus_write(REG_DATA, 8'($urandom_range(0, 255)));
            else
                bus_read(REG_DATA);
            if ($urandom_range(0, 7) == 0)
                bus_read(REG_CMD);
        end
    endtask

    task automatic seek_sequence();
        bus_write(REG_DATA, pick_edge_byte());
        case ($urandom_range(0, 2))
            0: bus_write(REG_CMD, CMD_SEEK_A);
            1: bus_write(REG_CMD, CMD_SEEK_B);
            default: bus_write(REG_CMD, CMD_RESTORE);
        endcase
        bus_read(REG_TRACK);
        bus_read(REG_CMD);
    endtask

    task automatic register_pokes();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 6))
                0: bus_write(REG_TRACK, pick_edge_byte());
                1: bus_read(REG_TRACK);
                2: bus_write(REG_SECTOR, pick_edge_byte());
                3: bus_read(REG_SECTOR);
                4: select_drive();
                5: bus_read(REG_DRVSEL);
                default: bus_read(REG_CMD);
            endcase
        end
    endtask

    task automatic buffer_burst();
        repeat ($urandom_range(1, 10))
            send_access($urandom_range(0, 1) ? ACT_BUF_LOAD : ACT_BUF_GET,
                        3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_access(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                        $urandom_range(0, 1) ? pick_command() : pick_edge_byte(),
                        8'($urandom_range(0, 255)));
    endtask

    task automatic run_random_phase(input logic [3:0] attach, input logic [3:0] wren,
                                    input int budget, input bit quiet);
        int start;
        int r;
        write_config(CFG_ATTACHED, attach);
        write_config(CFG_WR_EN, wren);
        no_idle = quiet;
        start   = items_sent;
        if (attach != 4'd0)
            full_write_sector();
        while (items_sent - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                full_write_sector();
            else if (r < 9)
                full_read_sector();
            else if (r < 33)
                partial_transfer();
            else if (r < 50)
                seek_sequence();
            else if (r < 65)
                buffer_burst();
            else if (r < 82)
                register_pokes();
            else
                noise_burst();
            if ($urandom_range(0, 29) == 0)
                wait_replies_drained();
        end
        no_idle = 1'b0;
    endtask

    task automatic test_register_basics();
        // nothing attached yet: status reads and commands set the not-ready bit and read back zero
        bus_read(REG_CMD);
        bus_write(REG_CMD, CMD_READ_A);
        bus_read(REG_DRVSEL);
        write_config(CFG_ATTACHED, 4'hF);
        write_config(CFG_WR_EN, 4'h7);
        // drive 3 is not writable, so selecting it sets the sticky protect bit
        bus_write(REG_DRVSEL, 8'hFF);
        bus_write(REG_TRACK, 8'hFF);
        bus_write(REG_SECTOR, 8'h00);
        bus_read(REG_SECTOR);
        bus_write(REG_SECTOR, 8'hFF);
        bus_write(REG_CMD, CMD_READ_B);
        bus_read(REG_CMD);
        bus_write(REG_CMD, CMD_WRITE);
        bus_write(REG_DRVSEL, 8'h00);
        bus_read(REG_CMD);
        bus_write(REG_CMD, CMD_WRITE);
        bus_read(REG_CMD);
        bus_read(REG_CMD);
        send_access(ACT_BUF_LOAD, REG_DRVSEL, 8'hFF, 8'h00);
        send_access(ACT_BUF_LOAD, REG_SPARE_HI, 8'h00, 8'hFF);
        send_access(ACT_BUF_GET, REG_DATA, 8'h00, 8'hFF);
        send_access(ACT_BUF_GET, REG_CMD, 8'hFF, 8'h00);
        bus_write(REG_DATA, 8'h5A);
        bus_write(REG_CMD, CMD_SEEK_A);
        bus_read(REG_TRACK);
        bus_write(REG_CMD, CMD_RESTORE);
        bus_write(REG_CMD, CMD_UNKNOWN);
        bus_read(REG_SPARE_LO);
        bus_write(REG_SPARE_HI, 8'hFF);
        bus_write(REG_CMD, CMD_READ_A);
        bus_read(REG_DATA);
    endtask

    // budgets leave room for the sector transfer that usually runs past the end of a phase
    task automatic test_all_drives_writable();
        run_random_phase(4'hF, 4'hF, 280, 1'b0);
    endtask

    task automatic test_mixed_masks();
        run_random_phase(4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)), 210, 1'b0);
    endtask

    task automatic test_protected_back_to_back();
        run_random_phase(4'hF, 4'h0, 150, 1'b1);
    endtask

    task automatic test_no_drives_attached();
        run_random_phase(4'h0, 4'h0, 90, 1'b0);
    endtask

    task automatic test_random_masks();
        run_random_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 90, 1'b0);
    endtask

    // sink side: random back-pressure, checks every beat against the oldest expectation
    always @(posedge clk) begin
        t_reply want;
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            ready_hold = pick_gap();
        end
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("beat with nothing expected", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[7:0] !== want.rd)
                    report_mismatch("read_data", 32'(m_tdata[7:0]), 32'(want.rd));
                if (m_tdata[9:8] !== want.req)
                    report_mismatch("storage_request", 32'(m_tdata[9:8]), 32'(want.req));
                if (m_tdata[11:10] !== want.drive)
                    report_mismatch("storage_drive", 32'(m_tdata[11:10]), 32'(want.drive));
                if (m_tdata[34:12] !== want.off)
                    report_mismatch("storage_offset", 32'(m_tdata[34:12]), 32'(want.off));
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        reset_registers();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_basics();
        test_all_drives_writable();
        test_mixed_masks();
        test_protected_back_to_back();
        test_no_drives_attached();
        test_random_masks();
        wait_replies_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
